>>> rtl/core/lmt_pkg.sv
package lmt_pkg;

    // Image geometry and sample format
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SAMPLE_BITS = 16;

    // Derived widths
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WID_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT + 2);
    localparam int ROWSUM_BITS = SAMPLE_BITS + 2;
    localparam int SUM_BITS    = SAMPLE_BITS + 4;
    localparam int CNT_BITS    = 4;

    // Fixed field widths
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int PIXEL_BITS   = 16;
    localparam int COORD_BITS   = 12;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_BITS  = $clog2(FIFO_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd4096;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd4096;

    // Request opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // 3x3 window: [row top/mid/bottom][col left/mid/right]
    typedef logic [2:0][2:0][SAMPLE_BITS-1:0] lmt_win_t;

    typedef struct packed {
        logic                  op;
        logic [PIXEL_BITS-1:0] pixel;
    } lmt_in_t;

    typedef struct packed {
        logic                  above_mean;
        logic [COORD_BITS-1:0] out_row;
        logic [COORD_BITS-1:0] out_col;
        logic                  last;
    } lmt_out_t;

    // Per-request result tag carried down the pipeline
    typedef struct packed {
        logic                  res;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  last;
        logic                  top_ok;
        logic                  bot_ok;
        logic                  left_ok;
        logic                  right_ok;
    } lmt_tag_t;

    // Request into the line-memory stage
    typedef struct packed {
        logic                valid;
        logic [COL_BITS-1:0] addr;
        sample_t             sample;
        lmt_tag_t            tag;
    } lmt_req_t;

endpackage

>>> rtl/core/lmt_ram.sv
module lmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> rtl/core/lmt_ctrl.sv
module lmt_ctrl import lmt_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata,
    input  logic                    in_accept,
    input  lmt_in_t                 in_data,
    output logic                    rd_en,
    output logic [COL_BITS-1:0]     rd_addr,
    output lmt_req_t                req
);

    logic [CFG_BITS-1:0] image_width_reg, image_height_reg;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    lmt_req_t            req_reg, req_next;

    logic [WID_BITS-1:0] w_eff;
    logic [ROW_BITS-1:0] h_eff, h_plus1;
    logic                stale, drain, take, col_nz, has_res, wrap, last;
    logic [COL_BITS-1:0] c, cc;
    logic [ROW_BITS-1:0] r, cr;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp geometry to the supported range
    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WID_BITS'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_eff = WID_BITS'(MAX_WIDTH);
        end else begin
            w_eff = WID_BITS'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_eff = ROW_BITS'(1);
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            h_eff = ROW_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_BITS'(image_height_reg);
        end
    end

    // Position, center coordinates and end-of-row/image flags of the incoming request
    always_comb begin
        h_plus1 = h_eff + ROW_BITS'(1);
        stale   = (WID_BITS'(col_reg) >= w_eff) || (row_reg > h_plus1) ||
                  ((row_reg == h_plus1) && (col_reg != '0));
        c       = stale ? '0 : col_reg;
        r       = stale ? '0 : row_reg;
        drain   = (r >= h_eff);
        take    = in_accept && !((in_data.op == OP_DRAIN) && !drain);
        col_nz  = (c != '0);
        has_res = col_nz ? (r >= ROW_BITS'(1)) : (r >= ROW_BITS'(2));
        cr      = col_nz ? (r - ROW_BITS'(1)) : (r - ROW_BITS'(2));
        cc      = col_nz ? (c - COL_BITS'(1)) : COL_BITS'(w_eff - WID_BITS'(1));
        last    = has_res && (cr == h_eff - ROW_BITS'(1)) &&
                  (WID_BITS'(cc) == w_eff - WID_BITS'(1));
        wrap    = (WID_BITS'(c) + WID_BITS'(1)) >= w_eff;
    end

    // Advance position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept) begin
            if (!take) begin
                col_next = c;
                row_next = r;
            end else if (last) begin
                col_next = '0;
                row_next = '0;
            end else if (wrap) begin
                col_next = '0;
                row_next = r + ROW_BITS'(1);
            end else begin
                col_next = c + COL_BITS'(1);
                row_next = r;
            end
        end
    end

    // Build the request for the line-memory stage
    always_comb begin
        req_next.valid        = take;
        req_next.addr         = c;
        req_next.sample       = drain ? '0 : SAMPLE_BITS'(in_data.pixel);
        req_next.tag.res      = has_res;
        req_next.tag.row      = COORD_BITS'(cr);
        req_next.tag.col      = COORD_BITS'(cc);
        req_next.tag.last     = last;
        req_next.tag.top_ok   = (cr != '0);
        req_next.tag.bot_ok   = (cr + ROW_BITS'(1)) < h_eff;
        req_next.tag.left_ok  = (cc != '0);
        req_next.tag.right_ok = (WID_BITS'(cc) + WID_BITS'(1)) < w_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            req_reg.valid <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            req_reg <= req_next;
        end
    end

    assign rd_en   = take;
    assign rd_addr = c;
    assign req     = req_reg;

endmodule

>>> rtl/core/lmt_window.sv
module lmt_window import lmt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lmt_req_t                 req,
    input  logic                     rd_take,
    input  logic [COL_BITS-1:0]      rd_addr,
    input  logic [2*SAMPLE_BITS-1:0] ram_rdata,
    output logic                     ram_we,
    output logic [COL_BITS-1:0]      ram_waddr,
    output logic [2*SAMPLE_BITS-1:0] ram_wdata,
    output logic                     win_valid,
    output lmt_win_t                 win,
    output lmt_tag_t                 win_tag
);

    logic                     fwd_hit_reg, fwd_hit_next;
    logic [2*SAMPLE_BITS-1:0] fwd_data_reg;
    logic [2*SAMPLE_BITS-1:0] line_data;
    sample_t                  older, prev;
    lmt_win_t                 win_reg, win_next;
    lmt_tag_t                 tag_reg;
    logic                     win_valid_reg;

    // Take line data from memory, or from the write that overlapped the read
    always_comb begin
        line_data = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        older     = line_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
        prev      = line_data[SAMPLE_BITS-1:0];
    end

    // Write back the shifted column: {older, prev} <= {prev, new sample}
    assign ram_we    = req.valid;
    assign ram_waddr = req.addr;
    assign ram_wdata = {prev, req.sample};

    // Flag a read that hits the entry being written this cycle
    assign fwd_hit_next = rd_take && req.valid && (rd_addr == req.addr);

    always_ff @(posedge aclk) begin
        fwd_data_reg <= ram_wdata;
    end

    // Shift the window left and load the new right column
    always_comb begin
        win_next = win_reg;
        if (req.valid) begin
            for (int i = 0; i < 3; i++) begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = older;
            win_next[1][2] = prev;
            win_next[2][2] = req.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg   <= 1'b0;
            win_valid_reg <= 1'b0;
            win_reg       <= '0;
        end else begin
            fwd_hit_reg   <= fwd_hit_next;
            win_valid_reg <= req.valid && req.tag.res;
            win_reg       <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= req.tag;
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;
    assign win_tag   = tag_reg;

endmodule

>>> rtl/core/lmt_classify.sv
module lmt_classify import lmt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     win_valid,
    input  lmt_win_t win,
    input  lmt_tag_t win_tag,
    output logic     stage_valid,
    output logic     push,
    output lmt_out_t push_data
);

    logic                   sum_valid_reg;
    logic [ROWSUM_BITS-1:0] row_sum_reg [3];
    logic [ROWSUM_BITS-1:0] row_sum_next [3];
    logic [SUM_BITS-1:0]    prod_reg, prod_next;
    logic [COORD_BITS-1:0]  row_reg, col_reg;
    logic                   last_reg;
    logic [2:0]             row_ok;
    logic [1:0]             rows_n, cols_n;
    logic [CNT_BITS-1:0]    count;
    logic [SUM_BITS-1:0]    total;

    // Masked row sums and center times in-image cell count
    always_comb begin
        row_ok = {win_tag.bot_ok, 1'b1, win_tag.top_ok};
        for (int i = 0; i < 3; i++) begin
            if (row_ok[i]) begin
                row_sum_next[i] =
                    (win_tag.left_ok  ? ROWSUM_BITS'(win[i][0]) : '0) +
                    ROWSUM_BITS'(win[i][1]) +
                    (win_tag.right_ok ? ROWSUM_BITS'(win[i][2]) : '0);
            end else begin
                row_sum_next[i] = '0;
            end
        end
        rows_n    = 2'd1 + 2'(win_tag.top_ok) + 2'(win_tag.bot_ok);
        cols_n    = 2'd1 + 2'(win_tag.left_ok) + 2'(win_tag.right_ok);
        count     = CNT_BITS'(rows_n) * CNT_BITS'(cols_n);
        prod_next = SUM_BITS'(win[1][1]) * SUM_BITS'(count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else begin
            sum_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge aclk) begin
        row_sum_reg <= row_sum_next;
        prod_reg    <= prod_next;
        row_reg     <= win_tag.row;
        col_reg     <= win_tag.col;
        last_reg    <= win_tag.last;
    end

    // Total the rows and compare against the scaled center
    always_comb begin
        total = SUM_BITS'(row_sum_reg[0]) + SUM_BITS'(row_sum_reg[1]) +
                SUM_BITS'(row_sum_reg[2]);
        push_data.above_mean = (prod_reg > total);
        push_data.out_row    = row_reg;
        push_data.out_col    = col_reg;
        push_data.last       = last_reg;
    end

    assign push        = sum_valid_reg;
    assign stage_valid = sum_valid_reg;

endmodule

>>> rtl/core/lmt_fifo.sv
module lmt_fifo import lmt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lmt_out_t           push_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lmt_out_t           m_data,
    output logic [FIFO_BITS:0] level
);

    lmt_out_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_BITS:0]   count_reg, count_next;
    logic                 pop;

    assign pop = m_valid && m_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + (FIFO_BITS+1)'(push) - (FIFO_BITS+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the result
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign level   = count_reg;

endmodule

>>> rtl/core/local_mean_threshold_3x3.sv
// A pixel's result is released by the request one row plus one pixel later and passes
// through the request, window, sum and result-queue registers on its way to m_valid.
// Throughput: one request per clock while s_ready is high; the line memory does one
// read-modify-write per request, bypassing when consecutive requests hit one column.
// Reset (aresetn low, synchronous): position, window, pipeline and result queue clear,
// both geometry registers return to 4096; the line memory is not cleared.
module local_mean_threshold_3x3 import lmt_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  lmt_in_t                 s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output lmt_out_t                m_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata
);

    logic                     in_accept;
    logic                     rd_en;
    logic [COL_BITS-1:0]      rd_addr;
    lmt_req_t                 req;
    logic [2*SAMPLE_BITS-1:0] ram_rdata;
    logic                     ram_we;
    logic [COL_BITS-1:0]      ram_waddr;
    logic [2*SAMPLE_BITS-1:0] ram_wdata;
    logic                     win_valid;
    lmt_win_t                 win;
    lmt_tag_t                 win_tag;
    logic                     stage_valid;
    logic                     push;
    lmt_out_t                 push_data;
    logic [FIFO_BITS:0]       level;
    logic [FIFO_BITS+1:0]     occupancy;

    // Accept only while every request in flight has a queue slot
    always_comb begin
        occupancy = (FIFO_BITS+2)'(level) + (FIFO_BITS+2)'(req.valid) +
                    (FIFO_BITS+2)'(win_valid) + (FIFO_BITS+2)'(stage_valid);
        s_ready   = occupancy < (FIFO_BITS+2)'(FIFO_DEPTH);
    end

    assign in_accept = s_valid && s_ready;

    lmt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_data   (s_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .req       (req)
    );

    // Line memory entry: {row two above, row above} at one column
    lmt_ram #(
        .WIDTH (2*SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    lmt_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .rd_take   (rd_en),
        .rd_addr   (rd_addr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .win_valid (win_valid),
        .win       (win),
        .win_tag   (win_tag)
    );

    lmt_classify u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .win_valid   (win_valid),
        .win         (win),
        .win_tag     (win_tag),
        .stage_valid (stage_valid),
        .push        (push),
        .push_data   (push_data)
    );

    lmt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .level     (level)
    );

endmodule

>>> test/tb_local_mean_threshold_3x3.sv
`timescale 1ns / 100ps

module tb_local_mean_threshold_3x3;
    import lmt_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1020;

    typedef enum int {PX_UNIFORM, PX_LOW, PX_RAILS, PX_HIGH} px_style_e;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    lmt_in_t                 s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    lmt_out_t                m_data;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_BITS-1:0]     cfg_wdata = '0;

    // Predictor state: geometry registers, line stores, window, raster position
    logic [CFG_BITS-1:0] geom_width  = WIDTH_RESET;
    logic [CFG_BITS-1:0] geom_height = HEIGHT_RESET;
    logic [SAMPLE_BITS-1:0] line_prev  [MAX_WIDTH] = '{default: '0};
    logic [SAMPLE_BITS-1:0] line_older [MAX_WIDTH] = '{default: '0};
    logic [SAMPLE_BITS-1:0] nbhd [3][3] = '{default: '0};
    int unsigned pos_row = 0;
    int unsigned pos_col = 0;

    lmt_in_t  pixel_stream [$];
    lmt_out_t pending_marks [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int items_sent     = 0;
    int src_gap        = 0;
    int sink_gap       = 0;
    bit src_calm       = 1'b0;
    bit sink_calm      = 1'b0;

    local_mean_threshold_3x3 u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic int unsigned clamp_dim(input logic [CFG_BITS-1:0] raw,
                                              input int unsigned top);
        if (raw == 0) return 1;
        if (raw > top) return top;
        return raw;
    endfunction

    // Position lies outside the image plus its drain
    function automatic bit pos_stale(input int unsigned w, input int unsigned h);
        return pos_col >= w || pos_row > h + 1 || (pos_row == h + 1 && pos_col != 0);
    endfunction

    // Advance the window by one request and queue the mark it releases, if any
    function automatic void classify_pixel(input lmt_in_t req);
        int unsigned w, h, r, c, sum, cnt, centre;
        int cr, cc, nr, nc;
        logic [SAMPLE_BITS-1:0] px, up1, up2;
        lmt_out_t mark;
        w = clamp_dim(geom_width, MAX_WIDTH);
        h = clamp_dim(geom_height, MAX_HEIGHT);
        if (pos_stale(w, h)) begin
            pos_col = 0;
            pos_row = 0;
        end
        r = pos_row;
        c = pos_col;
        // drop drain ticks inside the image
        if (req.op == OP_DRAIN && r < h) return;
        px  = (r >= h) ? '0 : req.pixel[SAMPLE_BITS-1:0];
        up2 = line_older[c];
        up1 = line_prev[c];
        line_older[c] = up1;
        line_prev[c]  = px;
        for (int i = 0; i < 3; i++) begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2] = up2;
        nbhd[1][2] = up1;
        nbhd[2][2] = px;
        // center sits one row plus one pixel behind the incoming sample in raster order
        if (c >= 1) begin
            cr = int'(r) - 1;
            cc = int'(c) - 1;
        end else begin
            cr = int'(r) - 2;
            cc = int'(w) - 1;
        end
        if (c + 1 >= w) begin
            pos_col = 0;
            pos_row = r + 1;
        end else begin
            pos_col = c + 1;
        end
        if (cr < 0) return;
        sum = 0;
        cnt = 0;
        for (int di = 0; di < 3; di++) begin
            for (int dj = 0; dj < 3; dj++) begin
                nr = cr + di - 1;
                nc = cc + dj - 1;
                if (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)) begin
                    sum += nbhd[di][dj];
                    cnt++;
                end
            end
        end
        centre = nbhd[1][1];
        mark.above_mean = (centre * cnt > sum);
        mark.out_row    = cr[COORD_BITS-1:0];
        mark.out_col    = cc[COORD_BITS-1:0];
        mark.last       = (cr == int'(h) - 1) && (cc == int'(w) - 1);
        pending_marks.push_back(mark);
        if (mark.last) begin
            pos_col = 0;
            pos_row = 0;
        end
    endfunction

    function automatic void note_field(input string field, input logic [COORD_BITS-1:0] want,
                                       input logic [COORD_BITS-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function automatic void check_mark(input lmt_out_t got);
        lmt_out_t want;
        if (pending_marks.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no result, got row %0d col %0d mark %0b",
                     $time, got.out_row, got.out_col, got.above_mean);
            return;
        end
        want = pending_marks.pop_front();
        note_field("above_mean", want.above_mean, got.above_mean);
        note_field("out_row", want.out_row, got.out_row);
        note_field("out_col", want.out_col, got.out_col);
        note_field("last", want.last, got.last);
    endfunction

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] draw_pixel(input px_style_e style);
        case (style)
            PX_LOW:   return PIXEL_BITS'($urandom_range(0, 3));
            PX_RAILS: return ($urandom_range(0, 1) == 1) ? '1 : '0;
            PX_HIGH:  return 16'hFFFC | PIXEL_BITS'($urandom_range(0, 3));
            default:  return PIXEL_BITS'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic op, input logic [PIXEL_BITS-1:0] px);
        lmt_in_t req;
        req.op    = op;
        req.pixel = px;
        pixel_stream.push_back(req);
    endtask

    // Queue raster positions from..upto-1 of a w x h image followed by its drain
    task automatic push_span(input int unsigned w, input int unsigned h,
                             input int unsigned from, input int unsigned upto,
                             input px_style_e style);
        for (int unsigned k = from; k < upto; k++) begin
            if (k < w * h) begin
                if ($urandom_range(0, 9) == 0) push_item(OP_DRAIN, PIXEL_BITS'($urandom));
                push_item(OP_PIXEL, draw_pixel(style));
            end else if ($urandom_range(0, 3) == 0) begin
                push_item(OP_PIXEL, PIXEL_BITS'($urandom));
            end else begin
                push_item(OP_DRAIN, '0);
            end
            items_sent++;
        end
    endtask

    // Sample away from the active edge so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge aclk);
        while (pixel_stream.size() != 0 || s_valid || pending_marks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) geom_width = val;
        else geom_height = val;
    endtask

    task automatic set_geometry(input logic [CFG_BITS-1:0] w_raw,
                                input logic [CFG_BITS-1:0] h_raw);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w_raw);
        write_reg(REG_IMAGE_HEIGHT, h_raw);
    endtask

    // Cut the current image short, shrink or reshape it, then finish from where it stands
    task automatic run_interrupted(input int unsigned cut, input logic [CFG_BITS-1:0] nw_raw,
                                   input logic [CFG_BITS-1:0] nh_raw, input px_style_e style);
        int unsigned cw, ch, nw, nh, start;
        cw = clamp_dim(geom_width, MAX_WIDTH);
        ch = clamp_dim(geom_height, MAX_HEIGHT);
        push_span(cw, ch, 0, cut, style);
        set_geometry(nw_raw, nh_raw);
        nw = clamp_dim(geom_width, MAX_WIDTH);
        nh = clamp_dim(geom_height, MAX_HEIGHT);
        start = pos_stale(nw, nh) ? 0 : pos_row * nw + pos_col;
        push_span(nw, nh, start, nh * nw + nw + 1, style);
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) classify_pixel(s_data);
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_stream.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pixel_stream.pop_front();
                    if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
                    src_gap = pick_gap(src_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else if (m_valid && m_ready) begin
            check_mark(m_data);
            if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
            sink_gap = pick_gap(sink_calm);
            m_ready <= (sink_gap == 0);
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= (sink_gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("local_mean_threshold_3x3 verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned cw, ch, nw, nh;
        px_style_e style;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // 3x3 image: rails, ties, a drain tick inside the image, a pixel in the drain
        set_geometry(3, 3);
        push_item(OP_PIXEL, 16'hFFFF);
        push_item(OP_PIXEL, 16'h0000);
        push_item(OP_PIXEL, 16'hFFFF);
        push_item(OP_DRAIN, 16'h1234);
        push_item(OP_PIXEL, 16'h0000);
        push_item(OP_PIXEL, 16'hFFFF);
        push_item(OP_PIXEL, 16'h0000);
        push_item(OP_PIXEL, 16'h0007);
        push_item(OP_PIXEL, 16'h0007);
        push_item(OP_PIXEL, 16'h0007);
        push_item(OP_DRAIN, 16'h0000);
        push_item(OP_PIXEL, 16'hAAAA);
        push_item(OP_DRAIN, 16'h5555);
        push_item(OP_DRAIN, 16'h0000);

        // oversize width clamps to the widest row: no result within its first columns
        set_geometry(13'h1FFF, 0);
        push_span(MAX_WIDTH, 1, 0, 40, PX_UNIFORM);

        // oversize height clamps to the tallest column: every center keeps a row below
        set_geometry(0, 13'h1FFF);
        push_span(1, MAX_HEIGHT, 0, 40, PX_LOW);

        // zero registers act as a 1x1 image; the tall column left the position stale
        set_geometry(0, 0);
        push_item(OP_PIXEL, 16'h5555);
        push_item(OP_DRAIN, 16'h0000);
        push_item(OP_DRAIN, 16'hFFFF);

        // full-size image cut short; the shrink leaves the position stale
        set_geometry(WIDTH_RESET, HEIGHT_RESET);
        run_interrupted(10, 5, 3, PX_UNIFORM);

        // random images, mostly well formed
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                nw = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 10) : $urandom_range(11, 48);
                nh = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 16);
                set_geometry((nw == 1 && $urandom_range(0, 1) == 1) ? 0 : nw,
                             (nh == 1 && $urandom_range(0, 1) == 1) ? 0 : nh);
            end
            cw = clamp_dim(geom_width, MAX_WIDTH);
            ch = clamp_dim(geom_height, MAX_HEIGHT);
            style = px_style_e'($urandom_range(0, 3));
            if (cw * ch > 1 && $urandom_range(0, 5) == 0)
                run_interrupted($urandom_range(1, cw * ch - 1), $urandom_range(1, cw),
                                $urandom_range(1, 8), style);
            else
                push_span(cw, ch, 0, cw * ch + cw + 1, style);
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("local_mean_threshold_3x3 verification clean");
        end else begin
            $display("local_mean_threshold_3x3 verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lmt_pkg.sv
rtl/core/lmt_ram.sv
rtl/core/lmt_ctrl.sv
rtl/core/lmt_window.sv
rtl/core/lmt_classify.sv
rtl/core/lmt_fifo.sv
rtl/core/local_mean_threshold_3x3.sv
test/tb_local_mean_threshold_3x3.sv
